>>> rtl/core/psi_pkg.sv
// Shared constants and types of the priority status indicator.
package psi_pkg;

    // Display state codes, lowest priority first.
    typedef enum logic [2:0] {
        ST_SLEEP     = 3'd0,
        ST_IDLE      = 3'd1,
        ST_BUSY      = 3'd2,
        ST_ATTENTION = 3'd3,
        ST_HEART     = 3'd4,
        ST_CELEBRATE = 3'd5,
        ST_DIZZY     = 3'd6,
        ST_UNUSED    = 3'd7
    } disp_state_t;

    // Event codes. Codes 6 and 7 behave as a tick.
    localparam logic [2:0] EV_TICK      = 3'd0;
    localparam logic [2:0] EV_START     = 3'd1;
    localparam logic [2:0] EV_END       = 3'd2;
    localparam logic [2:0] EV_ERROR     = 3'd3;
    localparam logic [2:0] EV_MILESTONE = 3'd4;
    localparam logic [2:0] EV_HEARTBEAT = 3'd5;

    // States reported with a heartbeat.
    localparam logic [1:0] REP_IDLE  = 2'd0;
    localparam logic [1:0] REP_BUSY  = 2'd1;
    localparam logic [1:0] REP_SLEEP = 2'd2;
    localparam logic [1:0] REP_ERROR = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_HOLD_ATTENTION = 3'd0;
    localparam logic [2:0] REG_HOLD_CELEBRATE = 3'd1;
    localparam logic [2:0] REG_DIZZY_HOLD     = 3'd2;
    localparam logic [2:0] REG_HEART_HOLD     = 3'd3;
    localparam logic [2:0] REG_QUICK_WORK     = 3'd4;
    localparam logic [2:0] REG_WARN_GAP       = 3'd5;
    localparam logic [2:0] REG_SLEEP_GAP      = 3'd6;

    localparam int PADDR_W = 5;
    localparam int HOLD_W  = 16;
    localparam int GAP_W   = 24;
    localparam int TIME_W  = 32;

    // Reset values of the registers.
    localparam logic [HOLD_W-1:0] HOLD_ATTENTION_RST = 16'd3000;
    localparam logic [HOLD_W-1:0] HOLD_CELEBRATE_RST = 16'd5000;
    localparam logic [HOLD_W-1:0] DIZZY_HOLD_RST     = 16'd3000;
    localparam logic [HOLD_W-1:0] HEART_HOLD_RST     = 16'd2000;
    localparam logic [HOLD_W-1:0] QUICK_WORK_RST     = 16'd3000;
    localparam logic [GAP_W-1:0]  WARN_GAP_RST       = 24'd30000;
    localparam logic [GAP_W-1:0]  SLEEP_GAP_RST      = 24'd300000;

    // Hold used for a state that has no register of its own.
    localparam logic [HOLD_W-1:0] HOLD_DEFAULT = 16'd3000;

endpackage

>>> rtl/core/psi_chan_if.sv
// Valid/ready channel interfaces for events in and display results out.
interface psi_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [1:0]  reported_state;
    logic [31:0] now_ms;

    modport source (output valid, output func, output reported_state, output now_ms,
                    input ready);
    modport sink (input valid, input func, input reported_state, input now_ms,
                  output ready);
endinterface

interface psi_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] shown_state;
    logic       disconnected;

    modport source (output valid, output shown_state, output disconnected, input ready);
    modport sink (input valid, input shown_state, input disconnected, output ready);
endinterface

>>> rtl/core/priority_status_indicator_fsm.sv
// Top level of the priority status indicator: event register, state update, result register.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    func, reported_state, now_ms
//   out_ch    source     valid/ready    shown_state, disconnected
//   apb       slave      psel/penable   7 registers at byte address 4*index
//
// Each event is captured in the event register and resolved from there into the
// result register; one event is taken every cycle while the result side does not
// stall. The state update is a single pass of adders and compares. Reset clears
// the control and indicator state and loads register defaults; the payload
// registers carry no reset, and nothing needs a sweep. A stalled result holds
// the event register, and the event port then stalls only once that register is also full.
module priority_status_indicator_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    psi_evt_if.sink                        in_ch,
    psi_res_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psi_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // Configuration registers
    logic [psi_pkg::HOLD_W-1:0] hold_attention_reg, hold_celebrate_reg;
    logic [psi_pkg::HOLD_W-1:0] dizzy_hold_reg, heart_hold_reg, quick_work_reg;
    logic [psi_pkg::GAP_W-1:0]  warn_gap_reg, sleep_gap_reg;

    // Event register
    logic                        ev_valid_reg;
    logic [2:0]                  ev_func_reg;
    logic [1:0]                  ev_rep_reg;
    logic [psi_pkg::TIME_W-1:0]  ev_now_reg;

    // Indicator state
    psi_pkg::disp_state_t        base_state_reg, base_state_next;
    psi_pkg::disp_state_t        ov_state_reg, ov_state_next;
    logic                        ov_active_reg, ov_active_next;
    logic [psi_pkg::TIME_W-1:0]  ov_deadline_reg, ov_deadline_next;
    logic [psi_pkg::TIME_W-1:0]  last_hb_reg, last_hb_next;
    logic [psi_pkg::TIME_W-1:0]  work_start_reg, work_start_next;
    logic                        link_lost_reg, link_lost_next;

    // Result register
    logic                        res_valid_reg;
    psi_pkg::disp_state_t        res_state_reg, res_state_next;

    logic                        advance;
    logic                        cfg_write;
    logic [2:0]                  cfg_idx;

    logic                        has_req;
    psi_pkg::disp_state_t        req_state;
    logic [psi_pkg::HOLD_W-1:0]  req_hold;
    logic [psi_pkg::TIME_W:0]    deadline_sum;
    logic [psi_pkg::TIME_W-1:0]  work_time;
    logic [psi_pkg::TIME_W-1:0]  gap;
    logic                        keep_ov;
    logic                        take_req;
    logic                        ov_expired;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[psi_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign advance      = !res_valid_reg || out_ch.ready;
    assign in_ch.ready  = !ev_valid_reg || advance;

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.shown_state  = res_state_reg;
    assign out_ch.disconnected = link_lost_reg;

    always_comb
    begin
        unique case (cfg_idx)
            psi_pkg::REG_HOLD_ATTENTION: prdata = {16'd0, hold_attention_reg};
            psi_pkg::REG_HOLD_CELEBRATE: prdata = {16'd0, hold_celebrate_reg};
            psi_pkg::REG_DIZZY_HOLD:     prdata = {16'd0, dizzy_hold_reg};
            psi_pkg::REG_HEART_HOLD:     prdata = {16'd0, heart_hold_reg};
            psi_pkg::REG_QUICK_WORK:     prdata = {16'd0, quick_work_reg};
            psi_pkg::REG_WARN_GAP:       prdata = {8'd0, warn_gap_reg};
            psi_pkg::REG_SLEEP_GAP:      prdata = {8'd0, sleep_gap_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_attention_reg <= psi_pkg::HOLD_ATTENTION_RST;
            hold_celebrate_reg <= psi_pkg::HOLD_CELEBRATE_RST;
            dizzy_hold_reg     <= psi_pkg::DIZZY_HOLD_RST;
            heart_hold_reg     <= psi_pkg::HEART_HOLD_RST;
            quick_work_reg     <= psi_pkg::QUICK_WORK_RST;
            warn_gap_reg       <= psi_pkg::WARN_GAP_RST;
            sleep_gap_reg      <= psi_pkg::SLEEP_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                psi_pkg::REG_HOLD_ATTENTION: hold_attention_reg <= pwdata[15:0];
                psi_pkg::REG_HOLD_CELEBRATE: hold_celebrate_reg <= pwdata[15:0];
                psi_pkg::REG_DIZZY_HOLD:     dizzy_hold_reg     <= pwdata[15:0];
                psi_pkg::REG_HEART_HOLD:     heart_hold_reg     <= pwdata[15:0];
                psi_pkg::REG_QUICK_WORK:     quick_work_reg     <= pwdata[15:0];
                psi_pkg::REG_WARN_GAP:       warn_gap_reg       <= pwdata[23:0];
                psi_pkg::REG_SLEEP_GAP:      sleep_gap_reg      <= pwdata[23:0];
                default:                     ;
            endcase
        end
    end

    // Event decode and state update for the event held in the event register.
    always_comb
    begin
        base_state_next = base_state_reg;
        work_start_next = work_start_reg;
        last_hb_next    = last_hb_reg;
        link_lost_next  = link_lost_reg;
        has_req         = 1'b0;
        req_state       = psi_pkg::ST_DIZZY;
        work_time       = ev_now_reg - work_start_reg;

        unique case (ev_func_reg)
            psi_pkg::EV_START:
            begin
                work_start_next = ev_now_reg;
                base_state_next = psi_pkg::ST_BUSY;
            end
            psi_pkg::EV_END:
            begin
                has_req         = 1'b1;
                req_state       = (work_time < {16'd0, quick_work_reg}) ?
                                  psi_pkg::ST_HEART : psi_pkg::ST_ATTENTION;
                base_state_next = psi_pkg::ST_IDLE;
            end
            psi_pkg::EV_ERROR:
            begin
                has_req   = 1'b1;
                req_state = psi_pkg::ST_DIZZY;
            end
            psi_pkg::EV_MILESTONE:
            begin
                has_req   = 1'b1;
                req_state = psi_pkg::ST_CELEBRATE;
            end
            psi_pkg::EV_HEARTBEAT:
            begin
                last_hb_next   = ev_now_reg;
                link_lost_next = 1'b0;
                unique case (ev_rep_reg)
                    psi_pkg::REP_ERROR:
                    begin
                        has_req   = 1'b1;
                        req_state = psi_pkg::ST_DIZZY;
                    end
                    psi_pkg::REP_BUSY:  base_state_next = psi_pkg::ST_BUSY;
                    psi_pkg::REP_SLEEP: base_state_next = psi_pkg::ST_SLEEP;
                    default:            base_state_next = psi_pkg::ST_IDLE;
                endcase
            end
            default: ;
        endcase

        unique case (req_state)
            psi_pkg::ST_ATTENTION: req_hold = hold_attention_reg;
            psi_pkg::ST_HEART:     req_hold = heart_hold_reg;
            psi_pkg::ST_CELEBRATE: req_hold = hold_celebrate_reg;
            psi_pkg::ST_DIZZY:     req_hold = dizzy_hold_reg;
            default:               req_hold = psi_pkg::HOLD_DEFAULT;
        endcase

        deadline_sum = {1'b0, ev_now_reg} + {17'd0, req_hold};
        keep_ov      = ov_active_reg && (req_state < ov_state_reg)
                       && (ev_now_reg < ov_deadline_reg);
        take_req     = has_req && !keep_ov;

        // A fresh override is already expired when its deadline did not move
        // past now: a zero hold or a deadline that wrapped around.
        if (take_req)
        begin
            ov_state_next    = req_state;
            ov_deadline_next = deadline_sum[psi_pkg::TIME_W-1:0];
            ov_expired       = (req_hold == '0) || deadline_sum[psi_pkg::TIME_W];
            ov_active_next   = !ov_expired;
        end
        else
        begin
            ov_state_next    = ov_state_reg;
            ov_deadline_next = ov_deadline_reg;
            ov_expired       = ev_now_reg >= ov_deadline_reg;
            ov_active_next   = ov_active_reg && !ov_expired;
        end

        gap = ev_now_reg - last_hb_next;
        if (last_hb_next != '0)
        begin
            if (gap >= {8'd0, sleep_gap_reg})
            begin
                base_state_next = psi_pkg::ST_SLEEP;
                link_lost_next  = 1'b1;
            end
            else if (gap >= {8'd0, warn_gap_reg})
            begin
                base_state_next = psi_pkg::ST_IDLE;
                link_lost_next  = 1'b1;
            end
            else
            begin
                link_lost_next = 1'b0;
            end
        end

        res_state_next = (ov_active_next && ov_state_next >= base_state_next) ?
                         ov_state_next : base_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            base_state_reg  <= psi_pkg::ST_SLEEP;
            ov_state_reg    <= psi_pkg::ST_IDLE;
            ov_active_reg   <= 1'b0;
            ov_deadline_reg <= '0;
            last_hb_reg     <= '0;
            work_start_reg  <= '0;
            link_lost_reg   <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                ev_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                res_valid_reg <= ev_valid_reg;
                if (ev_valid_reg)
                begin
                    base_state_reg  <= base_state_next;
                    ov_state_reg    <= ov_state_next;
                    ov_active_reg   <= ov_active_next;
                    ov_deadline_reg <= ov_deadline_next;
                    last_hb_reg     <= last_hb_next;
                    work_start_reg  <= work_start_next;
                    link_lost_reg   <= link_lost_next;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            ev_func_reg <= in_ch.func;
            ev_rep_reg  <= in_ch.reported_state;
            ev_now_reg  <= in_ch.now_ms;
        end
        if (advance && ev_valid_reg)
        begin
            res_state_reg <= res_state_next;
        end
    end

`ifndef SYNTH
    // Only attention and above are ever installed as a live override.
    a_ov_level: assert property (@(posedge clk) disable iff (!rst_n)
        ov_active_reg |-> ov_state_reg >= psi_pkg::ST_ATTENTION)
        else $error("override active with a state below attention");

    // The base state is never one of the override-only states.
    a_base_level: assert property (@(posedge clk) disable iff (!rst_n)
        base_state_reg <= psi_pkg::ST_BUSY)
        else $error("base state holds an override-only code");

    // A lost link needs a stored heartbeat time.
    a_link_hb: assert property (@(posedge clk) disable iff (!rst_n)
        link_lost_reg |-> last_hb_reg != '0)
        else $error("link lost with no heartbeat stored");

    // A held event is not dropped while the result side stalls.
    a_ev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg && !advance |=> ev_valid_reg && $stable(ev_now_reg))
        else $error("pending event lost during stall");

    // A result shown is never below the base state.
    a_res_floor: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ev_valid_reg |=> res_state_reg >= base_state_reg)
        else $error("shown state below base state");
`endif

endmodule
